// ===== rtl/trrt_pkg.sv =====
`default_nettype none

package trrt_pkg;

  // default counter width of the per-tree frontier counts
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // frontier ratio for expansion control, Q0.16
  localparam logic [15:0] FRONTIER_RATIO_Q16 = 16'd6554;

  // log2(e) in Q1.31 and ln(2) in Q0.32
  localparam logic [31:0] LOG2E_Q31 = 32'd3098164009;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;

  // shared divider width
  localparam int unsigned DIV_W = 128;

  // commands
  localparam logic CMD_EXTEND  = 1'b0;
  localparam logic CMD_CONNECT = 1'b1;

  // result outcome codes
  localparam logic [1:0] OUTC_ACCEPT = 2'd0;
  localparam logic [1:0] OUTC_EXPAND = 2'd1;
  localparam logic [1:0] OUTC_METRO  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COST_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_FACT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUCC_LIM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIM   = 3'd7;

  // configuration reset values
  localparam logic [31:0] MAX_STEP_RST   = 32'd65536;
  localparam logic [31:0] COST_SCALE_RST = 32'd65536;
  localparam logic [31:0] FRONT_LIM_RST  = 32'd655;
  localparam logic [11:0] TEMP_FACT_RST  = 12'd512;
  localparam logic [63:0] TEMP_FLOOR_RST = 64'd281475;
  localparam logic [63:0] TEMP_START_RST = 64'd2814749767;
  localparam logic [9:0]  SUCC_LIM_RST   = 10'd2;
  localparam logic [9:0]  FAIL_LIM_RST   = 10'd10;

  typedef struct packed {
    logic        cmd;
    logic        tree_sel;
    logic [31:0] motion_cost;
    logic [31:0] step_distance;
    logic [31:0] random_fraction;
  } trrt_in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  outcome;
    logic [63:0] temperature_now;
  } trrt_out_t;

  function automatic logic [63:0] trrt_isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // t[i] = 2^(-2^-(i+1)) scaled by 2^32, built by repeated square roots
  function automatic logic [15:0][31:0] trrt_root_tab();
    logic [15:0][31:0] tab;
    logic [63:0]       t;
    t = trrt_isqrt(64'h8000_0000_0000_0000);
    for (int i = 0; i < 16; i++) begin
      tab[i] = t[31:0];
      t = trrt_isqrt({t[31:0], 32'h0});
    end
    return tab;
  endfunction

  localparam logic [15:0][31:0] ROOT_TAB = trrt_root_tab();

endpackage

`default_nettype wire

// ===== rtl/trrt_transition_gate.sv =====
`default_nettype none
// Flow: an expansion-control reject goes straight to the result; a Metropolis test passes
// through the divider. A connect word first scales the temperature, a failure that heats
// it runs the scaling once more, and a success that cools it makes a second pass through the divider.
// One word in flight at a time; the divider is a 128-step restoring divider.
// Reset (rst_ni, async, active low): config to defaults, both trees to the start
// temperature with all counters zero, sequencer idle, no result pending.
module trrt_transition_gate #(
  parameter int unsigned COUNT_WIDTH = trrt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  trrt_pkg::trrt_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output trrt_pkg::trrt_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [trrt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [63:0]                         cfg_data_i
);
  import trrt_pkg::*;

  // sequencer codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_EXP  = 5'd1;   // expansion control, divisor clamp
  localparam logic [4:0] ST_H0   = 5'd2;   // T * factor, low half
  localparam logic [4:0] ST_H1   = 5'd3;   // T * factor, high half
  localparam logic [4:0] ST_H2   = 5'd4;   // /256 and saturate
  localparam logic [4:0] ST_DK   = 5'd5;   // div * k
  localparam logic [4:0] ST_DEN  = 5'd6;   // (div * k) * T, four partial products
  localparam logic [4:0] ST_ZCHK = 5'd7;   // zero denominator check, launch divide
  localparam logic [4:0] ST_MDIV = 5'd8;   // wait on x = cost / den
  localparam logic [4:0] ST_Y0   = 5'd9;   // x * log2(e), fraction part
  localparam logic [4:0] ST_Y1   = 5'd10;  // x * log2(e), integer part
  localparam logic [4:0] ST_POW  = 5'd11;  // 2^-f, one root per bit of the upper 16 bits of f
  localparam logic [4:0] ST_LIN  = 5'd12;  // linear tail g * ln2
  localparam logic [4:0] ST_LMUL = 5'd13;  // p * (1 - tail)
  localparam logic [4:0] ST_SHF  = 5'd14;  // 2^-n with rounding, compare
  localparam logic [4:0] ST_UPD  = 5'd15;  // counters, pick temperature change
  localparam logic [4:0] ST_CDIV = 5'd16;  // wait on cooling divide
  localparam logic [4:0] ST_DONE = 5'd17;  // load output register

  localparam logic [37:0] X_CAP = 38'h20_0000_0000;  // 32.0 in Q6.32

  // config
  logic [31:0] ms_q, cs_q, fl_q;
  logic [11:0] tf_q;
  logic [63:0] tfl_q;
  logic [9:0]  sl_q, flim_q;

  // per-tree state
  logic [63:0]            temp_q [2];
  logic [63:0]            temp_d [2];
  logic [9:0]             succ_q [2];
  logic [9:0]             succ_d [2];
  logic [9:0]             fail_q [2];
  logic [9:0]             fail_d [2];
  logic [COUNT_WIDTH-1:0] fr_q   [2];
  logic [COUNT_WIDTH-1:0] fr_d   [2];
  logic [COUNT_WIDTH-1:0] nf_q   [2];
  logic [COUNT_WIDTH-1:0] nf_d   [2];

  // control
  logic [4:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  // datapath
  logic        cmd_q, cmd_d, tree_q, tree_d;
  logic [31:0] cost_q, cost_d, dist_q, dist_d, rnd_q, rnd_d, dv_q, dv_d;
  logic [63:0] cur_t_q, cur_t_d, mtemp_q, mtemp_d, dk_q, dk_d;
  logic [127:0] acc_q, acc_d;
  logic [37:0] x_q, x_d;
  logic [39:0] y_q, y_d;
  logic [32:0] p_q, p_d;
  logic [16:0] lin_q, lin_d;
  logic        macc_q, macc_d, res_acc_q, res_acc_d;
  logic [1:0]  res_out_q, res_out_d;
  trrt_out_t   out_q, out_d;

  // shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p, mul_rnd;

  // divider
  logic         div_start, div_done;
  logic [127:0] div_num, div_den, div_quo;

  // helpers
  logic [31:0]              dv_w;
  logic [COUNT_WIDTH+15:0]  nf_shift;
  logic                     ec_rej;
  logic [1:0]               den_sh;
  logic [31:0]              frac_w;
  logic [33:0]              shf_tmp;
  logic [34:0]              shf_sum;
  logic [32:0]              p_fin;
  logic [63:0]              heat_w, cool_w;
  logic [9:0]               succ_inc, fail_inc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_EXP: begin
        mul_a = 33'(fr_q[tree_q]);
        mul_b = 33'(FRONTIER_RATIO_Q16);
      end
      ST_H0: begin
        mul_a = {1'b0, cur_t_q[31:0]};
        mul_b = 33'(tf_q);
      end
      ST_H1: begin
        mul_a = {1'b0, cur_t_q[63:32]};
        mul_b = 33'(tf_q);
      end
      ST_DK: begin
        mul_a = {1'b0, dv_q};
        mul_b = {1'b0, cs_q};
      end
      ST_DEN: begin
        mul_a = {1'b0, cnt_q[1] ? dk_q[63:32] : dk_q[31:0]};
        mul_b = {1'b0, cnt_q[0] ? mtemp_q[63:32] : mtemp_q[31:0]};
      end
      ST_Y0: begin
        mul_a = {1'b0, x_q[31:0]};
        mul_b = {1'b0, LOG2E_Q31};
      end
      ST_Y1: begin
        mul_a = 33'(x_q[37:32]);
        mul_b = {1'b0, LOG2E_Q31};
      end
      ST_POW: begin
        mul_a = p_q;
        mul_b = {1'b0, ROOT_TAB[cnt_q]};
      end
      ST_LIN: begin
        mul_a = 33'(y_q[15:0]);
        mul_b = {1'b0, LN2_Q32};
      end
      ST_LMUL: begin
        mul_a = p_q;
        mul_b = 33'h1_0000_0000 - 33'(lin_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_rnd = mul_p + 66'h8000_0000;  // round half up before >> 32

  assign dv_w     = (dist_q < ms_q) ? dist_q : ms_q;
  assign nf_shift = {nf_q[tree_q], 16'h0};
  assign ec_rej   = (cmd_q == CMD_EXTEND) && (mul_p[COUNT_WIDTH+15:0] < nf_shift)
                    && (dist_q <= fl_q);
  assign den_sh   = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
  assign frac_w   = y_q[31:0];

  // (p + 2^(n-1)) >> n as ((2p >> n) + 1) >> 1
  assign shf_tmp = {p_q, 1'b0} >> y_q[39:32];
  assign shf_sum = {1'b0, shf_tmp} + 35'd1;
  assign p_fin   = (y_q[39:32] >= 8'd33) ? '0 : shf_sum[33:1];

  assign heat_w = (|acc_q[127:72]) ? '1 : acc_q[71:8];
  assign cool_w = (|div_quo[127:64]) ? '1 : div_quo[63:0];

  assign succ_inc = (&succ_q[tree_q]) ? succ_q[tree_q] : succ_q[tree_q] + 10'd1;
  assign fail_inc = (&fail_q[tree_q]) ? fail_q[tree_q] : fail_q[tree_q] + 10'd1;

  assign div_num = (state_q == ST_ZCHK) ? {cost_q, 96'h0}
                                        : {56'h0, temp_q[tree_q], 8'h0};
  assign div_den = (state_q == ST_ZCHK) ? acc_q : 128'(tf_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    temp_d      = temp_q;
    succ_d      = succ_q;
    fail_d      = fail_q;
    fr_d        = fr_q;
    nf_d        = nf_q;
    cmd_d       = cmd_q;
    tree_d      = tree_q;
    cost_d      = cost_q;
    dist_d      = dist_q;
    rnd_d       = rnd_q;
    dv_d        = dv_q;
    cur_t_d     = cur_t_q;
    mtemp_d     = mtemp_q;
    dk_d        = dk_q;
    acc_d       = acc_q;
    x_d         = x_q;
    y_d         = y_q;
    p_d         = p_q;
    lin_d       = lin_q;
    macc_d      = macc_q;
    res_acc_d   = res_acc_q;
    res_out_d   = res_out_q;
    out_d       = out_q;
    div_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          tree_d  = in_data_i.tree_sel;
          cost_d  = in_data_i.motion_cost;
          dist_d  = in_data_i.step_distance;
          rnd_d   = in_data_i.random_fraction;
          state_d = ST_EXP;
        end
      end
      ST_EXP: begin
        dv_d    = dv_w;
        cur_t_d = temp_q[tree_q];
        mtemp_d = temp_q[tree_q];
        if (ec_rej) begin
          // rejected by expansion control: no state changes
          res_acc_d = 1'b0;
          res_out_d = OUTC_EXPAND;
          state_d   = ST_DONE;
        end else if (dv_w == '0) begin
          macc_d  = 1'b0;
          state_d = ST_UPD;
        end else if (cmd_q == CMD_CONNECT) begin
          state_d = ST_H0;
        end else begin
          state_d = ST_DK;
        end
      end
      ST_H0: begin
        acc_d   = 128'(mul_p[43:0]);
        state_d = ST_H1;
      end
      ST_H1: begin
        acc_d   = acc_q + (128'(mul_p[43:0]) << 32);
        state_d = ST_H2;
      end
      ST_H2: begin
        if (cmd_q == CMD_CONNECT) begin
          mtemp_d = heat_w;
          state_d = ST_DK;
        end else begin
          // heating after too many failures
          temp_d[tree_q] = heat_w;
          state_d        = ST_DONE;
        end
      end
      ST_DK: begin
        dk_d    = mul_p[63:0];
        acc_d   = '0;
        cnt_d   = '0;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        acc_d = acc_q + (128'(mul_p[63:0]) << {den_sh, 5'b0});
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          state_d = ST_ZCHK;
        end
      end
      ST_ZCHK: begin
        if (acc_q == '0) begin
          // zero k or zero temperature: p is 0
          macc_d  = (rnd_q == '0);
          state_d = ST_UPD;
        end else begin
          div_start = 1'b1;
          state_d   = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          x_d     = (|div_quo[127:37]) ? X_CAP : {1'b0, div_quo[36:0]};
          state_d = ST_Y0;
        end
      end
      ST_Y0: begin
        acc_d   = 128'(mul_p[63:0]);
        state_d = ST_Y1;
      end
      ST_Y1: begin
        y_d     = 40'(acc_q[63:31]) + 40'({mul_p[37:0], 1'b0});
        p_d     = 33'h1_0000_0000;
        cnt_d   = '0;
        state_d = ST_POW;
      end
      ST_POW: begin
        if (frac_w[~{1'b0, cnt_q}]) begin
          p_d = mul_rnd[64:32];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = ST_LIN;
        end
      end
      ST_LIN: begin
        lin_d   = mul_rnd[48:32];
        state_d = ST_LMUL;
      end
      ST_LMUL: begin
        if (lin_q != '0) begin
          p_d = mul_rnd[64:32];
        end
        state_d = ST_SHF;
      end
      ST_SHF: begin
        macc_d  = ({1'b0, rnd_q} <= p_fin);
        state_d = ST_UPD;
      end
      ST_UPD: begin
        res_acc_d = macc_q;
        res_out_d = macc_q ? OUTC_ACCEPT : OUTC_METRO;
        state_d   = ST_DONE;
        if (cmd_q == CMD_CONNECT) begin
          if (macc_q && !(&fr_q[tree_q])) begin
            fr_d[tree_q] = fr_q[tree_q] + 1'b1;
          end
        end else if (macc_q) begin
          if (dist_q > fl_q) begin
            if (!(&fr_q[tree_q])) fr_d[tree_q] = fr_q[tree_q] + 1'b1;
          end else begin
            if (!(&nf_q[tree_q])) nf_d[tree_q] = nf_q[tree_q] + 1'b1;
          end
          succ_d[tree_q] = succ_inc;
          if (succ_inc > sl_q) begin
            succ_d[tree_q] = '0;
            if (tf_q == '0) begin
              temp_d[tree_q] = '1;
            end else begin
              div_start = 1'b1;
              state_d   = ST_CDIV;
            end
          end
        end else begin
          fail_d[tree_q] = fail_inc;
          if (fail_inc > flim_q) begin
            fail_d[tree_q] = '0;
            state_d        = ST_H0;
          end
        end
      end
      ST_CDIV: begin
        if (div_done) begin
          temp_d[tree_q] = (cool_w < tfl_q) ? tfl_q : cool_w;
          state_d        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.accepted        = res_acc_q;
          out_d.outcome         = res_out_q;
          out_d.temperature_now = temp_q[tree_q];
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  trrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // control and per-tree state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        temp_q[i] <= TEMP_START_RST;
        succ_q[i] <= '0;
        fail_q[i] <= '0;
        fr_q[i]   <= '0;
        nf_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      temp_q      <= temp_d;
      succ_q      <= succ_d;
      fail_q      <= fail_d;
      fr_q        <= fr_d;
      nf_q        <= nf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    tree_q    <= tree_d;
    cost_q    <= cost_d;
    dist_q    <= dist_d;
    rnd_q     <= rnd_d;
    dv_q      <= dv_d;
    cur_t_q   <= cur_t_d;
    mtemp_q   <= mtemp_d;
    dk_q      <= dk_d;
    acc_q     <= acc_d;
    x_q       <= x_d;
    y_q       <= y_d;
    p_q       <= p_d;
    lin_q     <= lin_d;
    macc_q    <= macc_d;
    res_acc_q <= res_acc_d;
    res_out_q <= res_out_d;
    out_q     <= out_d;
  end

  // config registers; start temperature only matters at reset, so a write to it
  // has no visible effect and nothing is stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q   <= MAX_STEP_RST;
      cs_q   <= COST_SCALE_RST;
      fl_q   <= FRONT_LIM_RST;
      tf_q   <= TEMP_FACT_RST;
      tfl_q  <= TEMP_FLOOR_RST;
      sl_q   <= SUCC_LIM_RST;
      flim_q <= FAIL_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_STEP:   ms_q   <= cfg_data_i[31:0];
        REG_COST_SCALE: cs_q   <= cfg_data_i[31:0];
        REG_FRONT_LIM:  fl_q   <= cfg_data_i[31:0];
        REG_TEMP_FACT:  tf_q   <= cfg_data_i[11:0];
        REG_TEMP_FLOOR: tfl_q  <= cfg_data_i;
        REG_TEMP_START: ;
        REG_SUCC_LIM:   sl_q   <= cfg_data_i[9:0];
        REG_FAIL_LIM:   flim_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/trrt_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module trrt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [127:0]      num_i,
  input  logic [127:0]      den_i,
  output logic              done_o,
  output logic [127:0]      quo_o
);
  import trrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_W-1:0]  num_q;
  logic [DIV_W-1:0]  den_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              take;

  assign trial = {rem_q, num_q[DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_W-2:0], 1'b0};
      rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/trrt_chk.sv =====
`default_nettype none

module trrt_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input trrt_pkg::trrt_out_t  out_data_o
);
  import trrt_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // one word in flight: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // accept flag agrees with outcome
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.accepted == (out_data_o.outcome == OUTC_ACCEPT)))
    else $error("accept flag and outcome disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.outcome == OUTC_ACCEPT ||
                     out_data_o.outcome == OUTC_EXPAND ||
                     out_data_o.outcome == OUTC_METRO))
    else $error("bad outcome code");

endmodule

bind trrt_transition_gate trrt_chk u_trrt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== dv/tb_trrt_transition_gate.sv =====
`timescale 1ns / 100ps

module tb_trrt_transition_gate;
  import trrt_pkg::*;

  localparam int unsigned RUN_LIMIT = 1000000;  // cycles before the run is declared hung
  localparam int unsigned SETTLE_CYC = 8;       // idle cycles after the last result of a phase
  localparam int unsigned TAIL_CYC = 400;       // watch for strays after the last result
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] X_CAP = 64'd32 << 32;

  // Scoreboard: its own copy of the gate state, the verdicts still owed by the block,
  // and the mismatch count.
  class trrt_gate_scoreboard;
    logic [31:0] max_step, cost_k, front_lim;
    logic [11:0] tfac;
    logic [63:0] tfloor, tstart;
    logic [9:0]  succ_lim, fail_lim;
    logic [63:0] temp[2];
    logic [9:0]  succ[2], fails[2];
    logic [31:0] nfront[2], nnear[2];
    logic [31:0] roots[16];
    trrt_out_t   verdicts_due[$];
    int          errors;

    function new();
      logic [63:0] t;
      t = root(64'h8000_0000_0000_0000);
      for (int i = 0; i < 16; i++) begin
        roots[i] = t[31:0];
        t = root(t << 32);
      end
      max_step = 32'd65536;
      cost_k = 32'd65536;
      front_lim = 32'd655;
      tfac = 12'd512;
      tfloor = 64'd281475;
      tstart = 64'd2814749767;
      succ_lim = 10'd2;
      fail_lim = 10'd10;
      for (int i = 0; i < 2; i++) begin
        temp[i] = tstart;
        succ[i] = '0;
        fails[i] = '0;
        nfront[i] = '0;
        nnear[i] = '0;
      end
      errors = 0;
    endfunction

    // bitwise integer square root
    function logic [63:0] root(logic [63:0] v);
      logic [63:0] r, b, x;
      r = '0;
      x = v;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_MAX_STEP:   max_step = val[31:0];
        REG_COST_SCALE: cost_k = val[31:0];
        REG_FRONT_LIM:  front_lim = val[31:0];
        REG_TEMP_FACT:  tfac = val[11:0];
        REG_TEMP_FLOOR: tfloor = val;
        REG_TEMP_START: tstart = val;
        REG_SUCC_LIM:   succ_lim = val[9:0];
        REG_FAIL_LIM:   fail_lim = val[9:0];
        default: ;
      endcase
    endfunction

    // floor(T * factor / 256), saturating
    function logic [63:0] heat(logic [63:0] t);
      logic [127:0] w;
      w = ({64'b0, t} * {116'b0, tfac}) >> 8;
      return (w[127:64] != 0) ? '1 : w[63:0];
    endfunction

    // floor(T * 256 / factor), saturating; zero factor saturates
    function logic [63:0] cool(logic [63:0] t);
      logic [127:0] w;
      if (tfac == 0) return '1;
      w = ({64'b0, t} << 8) / {116'b0, tfac};
      return (w[127:64] != 0) ? '1 : w[63:0];
    endfunction

    // exp(-x), x in Q32.32, answer scaled by 2^32
    function logic [63:0] exp_neg(logic [63:0] x);
      logic [63:0] y, n, f, p, g, lin;
      y = (x >> 32) * 64'(LOG2E_Q31) * 2 + (((x & 64'hFFFF_FFFF) * 64'(LOG2E_Q31)) >> 31);
      n = y >> 32;
      f = y & 64'hFFFF_FFFF;
      p = ONE_Q32;
      if (n >= 33) return '0;
      for (int i = 1; i <= 16; i++)
        if (f[32-i]) p = (p * {32'b0, roots[i-1]} + 64'h8000_0000) >> 32;
      g = f & 64'hFFFF;
      lin = (g * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
      if (lin != 0) p = (p * (ONE_Q32 - lin) + 64'h8000_0000) >> 32;
      if (n > 0) p = (p + (64'd1 << (n - 1))) >> n;
      return p;
    endfunction

    function bit metropolis(logic [31:0] cost, logic [31:0] span, logic [63:0] t,
                            logic [31:0] rnd);
      logic [31:0]  dv;
      logic [63:0]  dk, x;
      logic [127:0] den, q;
      dv = (span < max_step) ? span : max_step;
      if (dv == 0) return 1'b0;
      dk = {32'b0, dv} * {32'b0, cost_k};
      den = {64'b0, dk} * {64'b0, t};
      if (den == 0) return rnd == 0;
      q = {cost, 96'b0} / den;
      x = (q >= {64'b0, X_CAP}) ? X_CAP : q[63:0];
      return {32'b0, rnd} <= exp_neg(x);
    endfunction

    // accepted input word: advance the tree state and queue the verdict it owes
    function void note_motion(trrt_in_t m);
      trrt_out_t   v;
      logic [63:0] fr, nf, nt;
      bit          acc;
      int          t;
      t = m.tree_sel;
      if (m.cmd == CMD_EXTEND) begin
        fr = {32'b0, nfront[t]} * 64'(FRONTIER_RATIO_Q16);
        nf = {32'b0, nnear[t]} << 16;
        if (fr < nf && m.step_distance <= front_lim) begin
          acc = 1'b0;
          v.outcome = OUTC_EXPAND;
        end else begin
          acc = metropolis(m.motion_cost, m.step_distance, temp[t], m.random_fraction);
          v.outcome = acc ? OUTC_ACCEPT : OUTC_METRO;
          if (acc) begin
            if (succ[t] != '1) succ[t]++;
            if (succ[t] > succ_lim) begin
              nt = cool(temp[t]);
              temp[t] = (nt < tfloor) ? tfloor : nt;
              succ[t] = '0;
            end
            if (m.step_distance > front_lim) begin
              if (nfront[t] != '1) nfront[t]++;
            end else begin
              if (nnear[t] != '1) nnear[t]++;
            end
          end else begin
            if (fails[t] != '1) fails[t]++;
            if (fails[t] > fail_lim) begin
              temp[t] = heat(temp[t]);
              fails[t] = '0;
            end
          end
        end
      end else begin
        acc = metropolis(m.motion_cost, m.step_distance, heat(temp[t]), m.random_fraction);
        v.outcome = acc ? OUTC_ACCEPT : OUTC_METRO;
        if (acc && nfront[t] != '1) nfront[t]++;
      end
      v.accepted = acc;
      v.temperature_now = temp[t];
      verdicts_due = {verdicts_due, v};
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(trrt_out_t got);
      trrt_out_t want;
      if (verdicts_due.size() == 0) begin
        report("result word with nothing outstanding");
        return;
      end
      want = verdicts_due.pop_front();
      if (got.accepted !== want.accepted)
        report($sformatf("accepted %0b, want %0b", got.accepted, want.accepted));
      if (got.outcome !== want.outcome)
        report($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
      if (got.temperature_now !== want.temperature_now)
        report($sformatf("temperature %h, want %h", got.temperature_now,
                         want.temperature_now));
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  trrt_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  trrt_out_t out_data_o;
  logic      cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [63:0] cfg_data_i;

  trrt_gate_scoreboard sb;
  bit          quiet;     // when set, neither side idles
  int unsigned cycles;
  int          ready_hold;

  trrt_transition_gate DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // starts low so that time zero is no rising edge
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // hang guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // both handshakes sampled at the edge; input noted before the result is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_motion(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_verdict(out_data_o);
    end
  end

  // receiver stalls: runs of ready or not-ready, mostly short, now and then long
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold == 0) begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
      ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 3);
    end else begin
      ready_hold = ready_hold - 1;
    end
  end

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  function automatic trrt_in_t motion(bit c, bit t, logic [31:0] cost, logic [31:0] span,
                                      logic [31:0] rnd);
    trrt_in_t m;
    m.cmd = c;
    m.tree_sel = t;
    m.motion_cost = cost;
    m.step_distance = span;
    m.random_fraction = rnd;
    return m;
  endfunction

  // random candidate: costs spread over all magnitudes, many short steps, some
  // zero divisors and random values pinned at the ends of the range
  function automatic trrt_in_t rand_motion();
    logic [31:0] cost, span, rnd;
    int unsigned r;
    r = $urandom_range(0, 99);
    cost = (r < 10) ? 32'd0 : ($urandom >> $urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 8) span = 32'd0;
    else if (r < 40) span = $urandom_range(0, 700);
    else span = $urandom >> $urandom_range(0, 16);
    r = $urandom_range(0, 99);
    if (r < 10) rnd = 32'd0;
    else if (r < 15) rnd = '1;
    else rnd = $urandom;
    return motion($urandom_range(0, 3) == 0, $urandom_range(0, 1), cost, span, rnd);
  endfunction

  // present one word; valid stays up across back-to-back words
  task send(trrt_in_t m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= m;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task send_random(int count);
    for (int i = 0; i < count; i++) send(rand_motion());
  endtask

  // wait for every owed verdict, then let the block settle; the half cycle lets the
  // monitor note the last accepted word first
  task drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    ready_hold = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    out_ready_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_MAX_STEP;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings
    send(motion(CMD_EXTEND, 0, 32'd0, 32'd100, '1));       // zero cost: sure accept, near node
    send(motion(CMD_EXTEND, 0, 32'd0, 32'd100, 32'd0));    // expansion control reject
    send(motion(CMD_EXTEND, 0, 32'd0, 32'd1000, '1));      // frontier accept
    send(motion(CMD_EXTEND, 0, 32'd0, '1, '1));            // third success cools
    send(motion(CMD_EXTEND, 1, 32'd5, 32'd0, 32'd0));      // zero divisor
    send(motion(CMD_CONNECT, 1, 32'd0, 32'd5, '1));
    send(motion(CMD_CONNECT, 0, '1, 32'd1, 32'd0));
    send(motion(CMD_CONNECT, 0, '1, '1, 32'd1));
    send(motion(CMD_EXTEND, 1, 32'd1, '1, 32'h8000_0000));
    send(motion(CMD_EXTEND, 1, 32'd3, 32'd65536, 32'h0000_FFFF));
    // enough failures on the goal tree to heat it
    for (int i = 0; i < 12; i++)
      send(motion(CMD_EXTEND, 1, '1, 32'd65536, '1));
    send_random(60);
    drain();

    // upper extremes
    cfg_write(REG_MAX_STEP, 64'hFFFF_FFFF);
    cfg_write(REG_COST_SCALE, 64'hFFFF_FFFF);
    cfg_write(REG_FRONT_LIM, 64'hFFFF_FFFF);
    cfg_write(REG_TEMP_FACT, 64'd2560);
    cfg_write(REG_TEMP_FLOOR, '1);
    cfg_write(REG_TEMP_START, 64'd0);
    cfg_write(REG_SUCC_LIM, 64'd1023);
    cfg_write(REG_FAIL_LIM, 64'd1000);
    send_random(70);
    drain();

    // lower extremes: zero divisor everywhere, then zero factor drives T to zero
    quiet = 1'b1;
    cfg_write(REG_MAX_STEP, 64'd0);
    cfg_write(REG_COST_SCALE, 64'd0);
    cfg_write(REG_FRONT_LIM, 64'd0);
    cfg_write(REG_TEMP_FACT, 64'd0);
    cfg_write(REG_TEMP_FLOOR, 64'd0);
    cfg_write(REG_SUCC_LIM, 64'd0);
    cfg_write(REG_FAIL_LIM, 64'd0);
    send_random(30);
    drain();
    quiet = 1'b0;

    // zero k: only a zero random value passes; each success cools by a zero factor
    cfg_write(REG_MAX_STEP, 64'h0010_0000);
    send_random(70);
    drain();

    // mid settings with tight limits
    cfg_write(REG_MAX_STEP, 64'd65536);
    cfg_write(REG_COST_SCALE, 64'd65536);
    cfg_write(REG_FRONT_LIM, 64'd655);
    cfg_write(REG_TEMP_FACT, 64'd300);
    cfg_write(REG_TEMP_FLOOR, 64'd281475);
    cfg_write(REG_SUCC_LIM, 64'd3);
    cfg_write(REG_FAIL_LIM, 64'd4);
    send_random(120);
    quiet = 1'b1;
    send_random(30);
    quiet = 1'b0;

    drain();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
